FILE: hw/rtl/dq16_pkg.sv
// ----------------------------------------------------------------------------
// dq16_pkg - shared types and constants for the decimal to q16.16 parser
// Character codes, parse states, reason codes, the controller/datapath
// command and status bundles, and the power-of-ten table.
// ----------------------------------------------------------------------------
package dq16_pkg;

  // default for the fraction digit limit (legal range 1 to 4)
  localparam int MAX_DECIMALS_DEF = 4;

  // ascii codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // largest integer prefix that may still take another digit
  localparam logic [14:0] INT_LIMIT = 15'd3276;

  // fraction divider runs one quotient bit per step
  localparam int DIV_STEPS = 16;

  // reason codes on the result
  typedef enum logic [2:0] {
    RS_OK       = 3'd0,
    RS_NOTNUM   = 3'd1,
    RS_BIG      = 3'd2,
    RS_DECIMALS = 3'd3,
    RS_NOPOINT  = 3'd4
  } reason_t;

  // controller states: parse phases plus the two result states
  typedef enum logic [2:0] {
    ST_START,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC,
    ST_FAIL,
    ST_DIVIDE,
    ST_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic    take_sign;
    logic    take_int;
    logic    take_frac;
    logic    div_start;
    logic    div_step;
    logic    load_out;
    reason_t reason;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic int_over;
    logic frac_full;
    logic has_frac;
    logic div_last;
    logic out_busy;
  } dp_status_t;

  // digit test
  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  // 10^n for n = 0..4, saturating at 10^4
  function automatic logic [13:0] pow_ten(input logic [2:0] n);
    logic [13:0] p;
    case (n)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/dq16_datapath.sv
// ----------------------------------------------------------------------------
// dq16_datapath - accumulators, fraction divider and result register
// Holds sign, integer and fraction accumulators, runs a restoring divide
// for the rounded fraction, and assembles the signed 16.16 result.
// ----------------------------------------------------------------------------
module dq16_datapath #(
  parameter int MAX_DECIMALS = dq16_pkg::MAX_DECIMALS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           character,
  input  dq16_pkg::dp_cmd_t    cmd,
  output dq16_pkg::dp_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 is_number,
  output logic [2:0]           reason,
  output logic signed [31:0]   value
);

  localparam int CNT_W = $clog2(dq16_pkg::DIV_STEPS);

  logic        negative;
  logic [14:0] integer_acc;
  logic [13:0] fraction_acc;
  logic [2:0]  fraction_count;

  logic [13:0] div_rem;
  logic [13:0] div_den;
  logic [15:0] div_half;
  logic [15:0] div_quo;
  logic [CNT_W-1:0] div_cnt;

  logic [3:0]  digit;
  logic [18:0] int_next;
  logic [17:0] frac_next;
  logic [13:0] den_sel;
  logic [14:0] div_trial;
  logic        div_ge;
  logic [31:0] magnitude;
  logic [31:0] signed_mag;

  // digit value and decimal shift-in
  assign digit     = 4'(character - dq16_pkg::CH_ZERO);
  assign int_next  = {1'b0, integer_acc, 3'b000} + {3'b000, integer_acc, 1'b0}
                   + {15'd0, digit};
  assign frac_next = {1'b0, fraction_acc, 3'b000} + {3'b000, fraction_acc, 1'b0}
                   + {14'd0, digit};

  // divisor for the current fraction length
  assign den_sel = dq16_pkg::pow_ten(fraction_count);

  // restoring divide step
  assign div_trial = {div_rem, div_half[15]};
  assign div_ge    = div_trial >= {1'b0, div_den};

  // result assembly: quotient is below 2^16 so it just fills the low half
  assign magnitude  = {1'b0, integer_acc, div_quo};
  assign signed_mag = negative ? (32'd0 - magnitude) : magnitude;

  // status toward the controller
  assign status.int_over  = (integer_acc > dq16_pkg::INT_LIMIT) ||
                            ((integer_acc == dq16_pkg::INT_LIMIT) &&
                             (character > dq16_pkg::CH_SEVEN));
  assign status.frac_full = fraction_count >= 3'(MAX_DECIMALS);
  assign status.has_frac  = fraction_count != 3'd0;
  assign status.div_last  = div_cnt == CNT_W'(dq16_pkg::DIV_STEPS - 1);
  assign status.out_busy  = out_valid && !out_ready;

  // accumulators, cleared as each result is loaded
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      negative       <= 1'b0;
      integer_acc    <= 15'd0;
      fraction_acc   <= 14'd0;
      fraction_count <= 3'd0;
    end else begin
      if (cmd.take_sign) negative <= 1'b1;
      if (cmd.take_int) integer_acc <= int_next[14:0];
      if (cmd.take_frac) begin
        fraction_acc   <= frac_next[13:0];
        fraction_count <= fraction_count + 3'd1;
      end
    end
  end

  // fraction divider: (f * 2^16 + d/2) / d, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem  <= fraction_acc;
      div_den  <= den_sel;
      div_half <= {3'b000, den_sel[13:1]};
      div_quo  <= 16'd0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      div_rem  <= div_ge ? 14'(div_trial - {1'b0, div_den}) : div_trial[13:0];
      div_half <= {div_half[14:0], 1'b0};
      div_quo  <= {div_quo[14:0], div_ge};
      div_cnt  <= div_cnt + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      is_number <= cmd.reason == dq16_pkg::RS_OK;
      reason    <= cmd.reason;
      value     <= (cmd.reason == dq16_pkg::RS_OK) ? signed_mag : 32'sd0;
    end
  end

endmodule

FILE: hw/rtl/dq16_controller.sv
// ----------------------------------------------------------------------------
// dq16_controller - parse state machine
// Classifies each character beat, steps the parse phase, keeps the first
// failure code, and sequences the divide and result load on the terminator.
// ----------------------------------------------------------------------------
module dq16_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           character,
  output dq16_pkg::dp_cmd_t    cmd,
  input  dq16_pkg::dp_status_t status
);

  dq16_pkg::ctrl_state_t state, state_next;
  dq16_pkg::reason_t     code, code_next;

  logic accept;
  logic ch_digit;
  logic ch_term;

  assign ch_digit = dq16_pkg::is_digit(character);
  assign ch_term  = character == dq16_pkg::CH_NUL;
  assign accept   = in_valid && in_ready;

  // state and failure code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq16_pkg::ST_START;
      code  <= dq16_pkg::RS_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.reason = code;
    in_ready   = (state != dq16_pkg::ST_DIVIDE) && (state != dq16_pkg::ST_FINISH);

    case (state)
      dq16_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = dq16_pkg::ST_FINISH;
      end

      dq16_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          code_next    = dq16_pkg::RS_OK;
          state_next   = dq16_pkg::ST_START;
        end
      end

      default: begin
        if (accept && ch_term) begin
          // terminator: settle the reason and start the result
          case (state)
            dq16_pkg::ST_INT,
            dq16_pkg::ST_FRAC:  code_next = dq16_pkg::RS_OK;
            dq16_pkg::ST_POINT: code_next = dq16_pkg::RS_NOPOINT;
            dq16_pkg::ST_FAIL:  code_next = code;
            default:            code_next = dq16_pkg::RS_NOTNUM;
          endcase
          cmd.div_start = 1'b1;
          if ((code_next == dq16_pkg::RS_OK) && status.has_frac) begin
            state_next = dq16_pkg::ST_DIVIDE;
          end else begin
            state_next = dq16_pkg::ST_FINISH;
          end
        end else if (accept) begin
          case (state)
            dq16_pkg::ST_START: begin
              if (character == dq16_pkg::CH_MINUS) begin
                cmd.take_sign = 1'b1;
                state_next    = dq16_pkg::ST_SIGN;
              end else if (ch_digit && status.int_over) begin
                code_next  = dq16_pkg::RS_BIG;
                state_next = dq16_pkg::ST_FAIL;
              end else if (ch_digit) begin
                cmd.take_int = 1'b1;
                state_next   = dq16_pkg::ST_INT;
              end else begin
                code_next  = dq16_pkg::RS_NOTNUM;
                state_next = dq16_pkg::ST_FAIL;
              end
            end

            dq16_pkg::ST_SIGN,
            dq16_pkg::ST_INT: begin
              if (ch_digit && status.int_over) begin
                code_next  = dq16_pkg::RS_BIG;
                state_next = dq16_pkg::ST_FAIL;
              end else if (ch_digit) begin
                cmd.take_int = 1'b1;
                state_next   = dq16_pkg::ST_INT;
              end else if ((state == dq16_pkg::ST_INT) &&
                           (character == dq16_pkg::CH_POINT)) begin
                state_next = dq16_pkg::ST_POINT;
              end else begin
                code_next  = dq16_pkg::RS_NOTNUM;
                state_next = dq16_pkg::ST_FAIL;
              end
            end

            dq16_pkg::ST_POINT,
            dq16_pkg::ST_FRAC: begin
              if (ch_digit && status.frac_full) begin
                code_next  = dq16_pkg::RS_DECIMALS;
                state_next = dq16_pkg::ST_FAIL;
              end else if (ch_digit) begin
                cmd.take_frac = 1'b1;
                state_next    = dq16_pkg::ST_FRAC;
              end else begin
                code_next  = (state == dq16_pkg::ST_POINT) ? dq16_pkg::RS_NOPOINT
                                                           : dq16_pkg::RS_NOTNUM;
                state_next = dq16_pkg::ST_FAIL;
              end
            end

            // failed: swallow bytes until the terminator
            default: begin
            end
          endcase
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/decimal_to_q16_parser.sv
// ----------------------------------------------------------------------------
// decimal_to_q16_parser - decimal text to signed 16.16 fixed point
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   character
//   output   out        out_valid / out_ready is_number, reason, value
//
// Characters other than the terminator are accepted whenever input is ready.
// A terminator is accepted, then the fraction divider runs when the number is
// valid and has a fraction, then the result register is loaded; input is not
// ready meanwhile, and the load waits while a previous result is unread.
// The result register lets the next string start while a result waits.
// Reset (rst, synchronous) returns to the start of a string, output empty.
// ----------------------------------------------------------------------------
module decimal_to_q16_parser #(
  parameter int MAX_DECIMALS = dq16_pkg::MAX_DECIMALS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         character,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_number,
  output logic [2:0]         reason,
  output logic signed [31:0] value
);

  dq16_pkg::dp_cmd_t    cmd;
  dq16_pkg::dp_status_t status;

  // parse control
  dq16_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .cmd       (cmd),
    .status    (status)
  );

  // accumulators, divider and result register
  dq16_datapath #(
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .character (character),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .is_number (is_number),
    .reason    (reason),
    .value     (value)
  );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - decimal_to_q16_parser self-checking bench
// Feeds NUL-terminated texts one character per beat: directed corner cases,
// mostly well-formed random numbers with some corruption, byte noise, and
// strings each drained before the next. A parse tracker predicts each result
// and a monitor compares every output beat field by field to the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_DIGITS = dq16_pkg::MAX_DECIMALS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic               num_ok;
    dq16_pkg::reason_t  why;
    logic signed [31:0] q16;
  } q16_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         character;
  logic               out_valid;
  logic               out_ready;
  logic               is_number;
  logic [2:0]         reason;
  logic signed [31:0] value;

  // predicted results not yet seen on the output
  q16_result_t results_due[$];
  // text being assembled for the next string, terminator not included
  logic [7:0]  text_buf[$];

  // parse tracker state
  dq16_pkg::ctrl_state_t trk_phase;
  logic                  trk_neg;
  logic [14:0]           trk_int;
  logic [13:0]           trk_frac;
  logic [2:0]            trk_count;
  dq16_pkg::reason_t     trk_fail;

  int  cycles;
  int  mismatches;
  int  chars_sent;
  int  results_seen;
  logic quiet_tx;
  logic quiet_rx;

  decimal_to_q16_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_number (is_number),
    .reason    (reason),
    .value     (value)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // parse tracker
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] ten_power(input logic [2:0] n);
    case (n)
      3'd0:    return 64'd1;
      3'd1:    return 64'd10;
      3'd2:    return 64'd100;
      3'd3:    return 64'd1000;
      default: return 64'd10000;
    endcase
  endfunction

  task automatic trk_clear();
    trk_phase = dq16_pkg::ST_START;
    trk_neg   = 1'b0;
    trk_int   = '0;
    trk_frac  = '0;
    trk_count = '0;
    trk_fail  = dq16_pkg::RS_OK;
  endtask

  task automatic trk_fail_with(input dq16_pkg::reason_t code);
    trk_phase = dq16_pkg::ST_FAIL;
    trk_fail  = code;
  endtask

  // integer digit, refused once the prefix cannot stay below 32768
  task automatic trk_int_digit(input logic [7:0] c);
    logic [31:0] acc;
    if (trk_int > dq16_pkg::INT_LIMIT ||
        (trk_int == dq16_pkg::INT_LIMIT && c > dq16_pkg::CH_SEVEN)) begin
      trk_fail_with(dq16_pkg::RS_BIG);
    end else begin
      acc       = 32'(trk_int) * 32'd10 + 32'(c - dq16_pkg::CH_ZERO);
      trk_int   = acc[14:0];
      trk_phase = dq16_pkg::ST_INT;
    end
  endtask

  // fraction digit, refused past the decimal limit
  task automatic trk_frac_digit(input logic [7:0] c);
    logic [31:0] acc;
    if (int'(trk_count) >= FRAC_DIGITS) begin
      trk_fail_with(dq16_pkg::RS_DECIMALS);
    end else begin
      trk_count = trk_count + 3'd1;
      acc       = 32'(trk_frac) * 32'd10 + 32'(c - dq16_pkg::CH_ZERO);
      trk_frac  = acc[13:0];
      trk_phase = dq16_pkg::ST_FRAC;
    end
  endtask

  // advance the tracker by one accepted character
  task automatic trk_char(input logic [7:0] c);
    logic        dig;
    logic [31:0] v;
    logic [63:0] den;
    logic [63:0] fq;
    q16_result_t r;
    dig = (c >= dq16_pkg::CH_ZERO) && (c <= dq16_pkg::CH_NINE);
    if (c == dq16_pkg::CH_NUL) begin
      case (trk_phase)
        dq16_pkg::ST_INT, dq16_pkg::ST_FRAC: r.why = dq16_pkg::RS_OK;
        dq16_pkg::ST_POINT:                  r.why = dq16_pkg::RS_NOPOINT;
        dq16_pkg::ST_FAIL:                   r.why = trk_fail;
        default:                             r.why = dq16_pkg::RS_NOTNUM;
      endcase
      r.num_ok = (r.why == dq16_pkg::RS_OK);
      r.q16    = '0;
      if (r.why == dq16_pkg::RS_OK) begin
        v = {1'b0, trk_int, 16'h0000};
        if (trk_count != 3'd0) begin
          den = ten_power(trk_count);
          fq  = (64'(trk_frac) * 64'd65536 + den / 64'd2) / den;
          v   = v + fq[31:0];
        end
        if (trk_neg)
          v = 32'd0 - v;
        r.q16 = v;
      end
      results_due.push_back(r);
      trk_clear();
    end else begin
      case (trk_phase)
        dq16_pkg::ST_START: begin
          if (c == dq16_pkg::CH_MINUS) begin
            trk_neg   = 1'b1;
            trk_phase = dq16_pkg::ST_SIGN;
          end else if (dig) begin
            trk_int_digit(c);
          end else begin
            trk_fail_with(dq16_pkg::RS_NOTNUM);
          end
        end
        dq16_pkg::ST_SIGN: begin
          if (dig) trk_int_digit(c);
          else trk_fail_with(dq16_pkg::RS_NOTNUM);
        end
        dq16_pkg::ST_INT: begin
          if (dig) trk_int_digit(c);
          else if (c == dq16_pkg::CH_POINT) trk_phase = dq16_pkg::ST_POINT;
          else trk_fail_with(dq16_pkg::RS_NOTNUM);
        end
        dq16_pkg::ST_POINT: begin
          if (dig) trk_frac_digit(c);
          else trk_fail_with(dq16_pkg::RS_NOPOINT);
        end
        dq16_pkg::ST_FRAC: begin
          if (dig) trk_frac_digit(c);
          else trk_fail_with(dq16_pkg::RS_NOTNUM);
        end
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one character beat, entered and left at a falling edge
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    character = c;
    do @(posedge clk); while (!in_ready);
    trk_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  // the assembled text followed by its terminator
  task automatic send_text();
    quiet_tx = ($urandom_range(0, 3) == 0);
    foreach (text_buf[i])
      send_char(text_buf[i]);
    send_char(dq16_pkg::CH_NUL);
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++)
      text_buf.push_back(s[i]);
  endtask

  task automatic add_decimal(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++)
      text_buf.push_back(s[i]);
  endtask

  // number text with random sign, magnitude and decimals, some too big or malformed
  task automatic build_number();
    int ival;
    int nfrac;
    text_buf.delete();
    if ($urandom_range(0, 1) == 1)
      text_buf.push_back(dq16_pkg::CH_MINUS);
    if ($urandom_range(0, 5) == 0)
      text_buf.push_back(dq16_pkg::CH_ZERO);
    case ($urandom_range(0, 9))
      0, 1, 2: ival = $urandom_range(0, 99);
      3, 4, 5: ival = $urandom_range(0, 32767);
      6, 7:    ival = $urandom_range(32760, 32799);
      8:       ival = $urandom_range(32768, 99999);
      default: ival = 32767;
    endcase
    add_decimal(ival);
    if ($urandom_range(0, 3) != 0) begin
      text_buf.push_back(dq16_pkg::CH_POINT);
      if ($urandom_range(0, 9) == 0)
        nfrac = $urandom_range(0, 1) * 5;
      else
        nfrac = $urandom_range(1, 4);
      for (int i = 0; i < nfrac; i++)
        text_buf.push_back(dq16_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic wait_results_drained();
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  initial begin : result_monitor
    int stall;
    q16_result_t e;
    out_ready    = 1'b0;
    quiet_rx     = 1'b0;
    results_seen = 0;
    mismatches   = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: is_number=%0b reason=%0d value=%0d",
                   is_number, reason, value);
        mismatches++;
      end else begin
        e = results_due.pop_front();
        if (is_number !== e.num_ok || reason !== e.why || value !== e.q16) begin
          if (mismatches < 10)
            $display("mismatch: expected is_number=%0b reason=%0d value=%0d, got %0b %0d %0d",
                     e.num_ok, e.why, e.q16, is_number, reason, value);
          mismatches++;
        end
      end
      results_seen++;
      // alternate between stalling and stall-free stretches
      if (results_seen % 16 == 0)
        quiet_rx = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner cases of the grammar and the value extremes
  task automatic test_corner_texts();
    load_text("");             send_text();
    load_text("-");            send_text();
    load_text("-0");           send_text();
    load_text("32768");        send_text();
    load_text("-32767.9999");  send_text();
    load_text("32767.9999");   send_text();
    load_text("1.");           send_text();
    load_text("1.x");          send_text();
    load_text("9.00001");      send_text();
    load_text("7a");           send_text();
    load_text("\377");         send_text();
    load_text("\001");         send_text();
  endtask

  // mostly well-formed numbers, some with a byte replaced or appended
  task automatic test_random_numbers();
    int pos;
    while (chars_sent < 910) begin
      build_number();
      case ($urandom_range(0, 7))
        0: begin
          pos = $urandom_range(0, text_buf.size() - 1);
          text_buf[pos] = 8'($urandom_range(1, 255));
        end
        1: text_buf.push_back(8'($urandom_range(1, 255)));
        default: ;
      endcase
      send_text();
    end
  endtask

  // short texts mixing arbitrary bytes and number characters in random order
  task automatic test_byte_noise();
    int len;
    logic [7:0] alpha[4];
    alpha = '{dq16_pkg::CH_MINUS, dq16_pkg::CH_POINT, dq16_pkg::CH_ZERO,
              dq16_pkg::CH_NINE};
    repeat (40) begin
      text_buf.delete();
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 1) == 1)
          text_buf.push_back(8'($urandom_range(1, 255)));
        else
          text_buf.push_back(alpha[2'($urandom_range(0, 3))]);
      end
      send_text();
    end
  endtask

  // sender holds off until the output side has caught up after each string
  task automatic test_drained_strings();
    repeat (12) begin
      build_number();
      send_text();
      in_valid = 1'b0;
      wait_results_drained();
    end
  endtask

  initial begin : stimulus
    rst        = 1'b1;
    in_valid   = 1'b0;
    character  = 8'h00;
    quiet_tx   = 1'b0;
    chars_sent = 0;
    trk_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_texts();
    test_random_numbers();
    test_byte_noise();
    test_drained_strings();

    in_valid = 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
